>>> src/dtrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtrd_pkg: shared constants and tables for the thermal refresh derate block
// memory type codes, register indexes, coefficient tables and datapath widths
// ----------------------------------------------------------------------------
package dtrd_pkg;

    // memory type codes
    localparam logic [2:0] DRAM_DDR4   = 3'd1;
    localparam logic [2:0] DRAM_LPDDR4 = 3'd2;
    localparam logic [2:0] DRAM_LPDDR5 = 3'd6;

    // configuration register indexes
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] REG_MEM_TYPE      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DATA_RATE     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_REVERSE_BITS  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_REFRESH_COUNT = 2'd3;

    // refresh registers per update
    localparam logic [3:0] MAX_REGS = 4'd8;

    // datapath widths
    localparam int unsigned BASE_W  = 15;   // (rate / 2) - 1
    localparam int unsigned COEFF_W = 11;   // largest coefficient 1560
    localparam int unsigned PROD_W  = BASE_W + COEFF_W;
    localparam int unsigned RECIP_W = 26;
    localparam int unsigned FULL_W  = 19;   // largest quotient 511149
    localparam int unsigned WIDE_W  = PROD_W + RECIP_W;

    // floor(2^32 / 100): quotient estimate is low by at most one
    localparam logic [RECIP_W-1:0] RECIP_100 = 26'd42949672;
    localparam logic [PROD_W-1:0]  COEFF_DIV = 26'd100;

    function automatic logic [COEFF_W-1:0] ddr4_derate_pct(input logic [1:0] lvl);
        logic [COEFF_W-1:0] c;
        case (lvl)
            2'd0:    c = 11'd780;
            2'd1:    c = 11'd780;
            2'd2:    c = 11'd390;
            default: c = 11'd195;
        endcase
        return c;
    endfunction

    function automatic logic [COEFF_W-1:0] lpddr4_derate_pct(input logic [2:0] lvl);
        logic [COEFF_W-1:0] c;
        case (lvl)
            3'd0:    c = 11'd1560;
            3'd1:    c = 11'd1560;
            3'd2:    c = 11'd780;
            3'd3:    c = 11'd390;
            3'd4:    c = 11'd195;
            3'd5:    c = 11'd97;
            3'd6:    c = 11'd97;
            default: c = 11'd48;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

>>> src/dram_thermal_refresh_derate.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dram_thermal_refresh_derate: refresh interval derating from sensor level
// turns temperature sensor words into refresh register low-half updates
// ----------------------------------------------------------------------------
// usage
//   s_ channel carries one raw 32-bit sensor word per request. the level is
//   taken from a bit field chosen by dram_type; a level equal to the stored
//   one, an unsupported type or a zero register count gives no result.
//   a new level gives refresh_reg_count results (capped at eight), one per
//   refresh register, on the m_ channel; m_tlast marks the last of them.
//   cfg_wr_en / cfg_addr / cfg_wdata write the four registers; write them
//   only while the block is idle.
// timing
//   the first result leaves the output register after the request has
//   passed the input, product, reciprocal and emit stages, then one
//   result per cycle while m_tready is high. a request with no result
//   flows at one per cycle unless a later stage stalls; a level change
//   holds the emit stage until its results are out, setting the sustained rate.
// reset and stall
//   aresetn clears the pipeline, forgets the stored level and loads the
//   register defaults. a stalled m_tready holds the output register and the
//   stall ripples back stage by stage to s_tready; nothing is dropped.
// ----------------------------------------------------------------------------
module dram_thermal_refresh_derate (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration write port
    input  wire logic                                cfg_wr_en,
    input  wire logic [dtrd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [dtrd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // sensor requests
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [31:0]                         s_tdata,   // [31:0] sensor_word
    // refresh updates
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [23:0]                              m_tdata,   // [2:0] reg_index,
                                                                // [18:3] refresh_value,
                                                                // [21:19] level, [23:22] zero
    output logic                                     m_tlast    // last_of_run
);

    // configuration registers
    logic [2:0]                    dram_type_reg;
    logic [15:0]                   dram_rate_reg;
    logic                          reverse_bits_reg;
    logic [3:0]                    reg_count_reg;

    // level tracking
    logic [2:0]                    last_level_reg;
    logic                          level_known_reg;

    // input stage
    logic                          s1_valid_reg;
    logic [31:0]                   s1_word_reg;

    // product stage
    logic                          s2_valid_reg;
    logic [dtrd_pkg::PROD_W-1:0]   s2_prod_reg;
    logic [2:0]                    s2_level_reg;
    logic [3:0]                    s2_count_reg;

    // reciprocal stage
    logic                          s3_valid_reg;
    logic [dtrd_pkg::PROD_W-1:0]   s3_prod_reg;
    logic [dtrd_pkg::FULL_W-1:0]   s3_quot_reg;
    logic [2:0]                    s3_level_reg;
    logic [3:0]                    s3_count_reg;

    // emit stage: one refresh register per cycle while the output can load
    logic                          job_valid_reg;
    logic [dtrd_pkg::FULL_W-1:0]   job_full_reg;
    logic [2:0]                    job_level_reg;
    logic [3:0]                    job_count_reg;
    logic [2:0]                    job_idx_reg;

    // output register
    logic                          m_valid_reg;
    logic [2:0]                    m_index_reg;
    logic [15:0]                   m_value_reg;
    logic [2:0]                    m_level_reg;
    logic                          m_last_reg;

    // flow control
    logic out_load_ok, emit, job_last, job_free, s3_free, s2_free, s1_free, s1_fire;

    // input stage decode
    logic [2:0]                    s1_level;
    logic [dtrd_pkg::COEFF_W-1:0]  s1_coeff;
    logic                          s1_supported;
    logic                          s1_changed;
    logic [3:0]                    s1_count;
    logic                          s1_emit;
    logic [dtrd_pkg::BASE_W-1:0]   s1_base;
    logic [dtrd_pkg::PROD_W-1:0]   s1_prod;

    // reciprocal multiply and correction
    logic [dtrd_pkg::WIDE_W-1:0]   s2_wide;
    logic [dtrd_pkg::PROD_W-1:0]   s3_rem;
    logic [dtrd_pkg::FULL_W-1:0]   s3_full;

    // emit datapath
    logic [dtrd_pkg::FULL_W-1:0]   job_shifted;
    logic [15:0]                   job_value;

    // ready chain, from the output register back to the input
    assign out_load_ok = !m_valid_reg || m_tready;
    assign emit        = job_valid_reg && out_load_ok;
    assign job_last    = ({1'b0, job_idx_reg} + 4'd1) == job_count_reg;
    assign job_free    = !job_valid_reg || (emit && job_last);
    assign s3_free     = !s3_valid_reg || job_free;
    assign s2_free     = !s2_valid_reg || s3_free;
    assign s1_free     = !s1_valid_reg || s2_free;
    assign s1_fire     = s1_valid_reg && s2_free;
    assign s_tready    = s1_free;

    // level field and coefficient by memory type
    always_comb begin
        s1_level     = 3'd0;
        s1_coeff     = '0;
        s1_supported = 1'b0;
        case (dram_type_reg)
            dtrd_pkg::DRAM_DDR4: begin
                s1_level     = reverse_bits_reg ? {1'b0, s1_word_reg[3], s1_word_reg[4]}
                                                : {1'b0, s1_word_reg[4:3]};
                s1_coeff     = dtrd_pkg::ddr4_derate_pct(s1_level[1:0]);
                s1_supported = 1'b1;
            end
            dtrd_pkg::DRAM_LPDDR4: begin
                s1_level     = s1_word_reg[2:0];
                s1_coeff     = dtrd_pkg::lpddr4_derate_pct(s1_level);
                s1_supported = 1'b1;
            end
            dtrd_pkg::DRAM_LPDDR5: begin
                // all lpddr5 coefficients are zero
                s1_level     = {2'b00, s1_word_reg[0]};
                s1_supported = 1'b1;
            end
            default: begin
                s1_supported = 1'b0;
            end
        endcase
    end

    assign s1_changed = !level_known_reg || (s1_level != last_level_reg);
    assign s1_count   = (reg_count_reg > dtrd_pkg::MAX_REGS) ? dtrd_pkg::MAX_REGS
                                                             : reg_count_reg;
    assign s1_emit    = s1_supported && s1_changed && (s1_count != 4'd0);

    // rate below two clamps the scaled rate to zero
    assign s1_base = (dram_rate_reg >= 16'd2) ? (dram_rate_reg[15:1] - 15'd1) : '0;
    assign s1_prod = dtrd_pkg::PROD_W'(s1_base) * dtrd_pkg::PROD_W'(s1_coeff);

    // divide by 100: reciprocal estimate, then one correction step
    assign s2_wide = dtrd_pkg::WIDE_W'(s2_prod_reg) * dtrd_pkg::WIDE_W'(dtrd_pkg::RECIP_100);
    assign s3_rem  = s3_prod_reg
                   - dtrd_pkg::PROD_W'(dtrd_pkg::PROD_W'(s3_quot_reg) * dtrd_pkg::COEFF_DIV);
    assign s3_full = (s3_rem >= dtrd_pkg::COEFF_DIV) ? (s3_quot_reg + 1'b1) : s3_quot_reg;

    // halve per register index, saturate to 16 bits
    assign job_shifted = job_full_reg >> job_idx_reg;
    assign job_value   = (job_shifted[dtrd_pkg::FULL_W-1:16] != '0) ? 16'hffff
                                                                    : job_shifted[15:0];

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dram_type_reg    <= dtrd_pkg::DRAM_DDR4;
            dram_rate_reg    <= 16'd0;
            reverse_bits_reg <= 1'b0;
            reg_count_reg    <= 4'd1;
            last_level_reg   <= 3'd0;
            level_known_reg  <= 1'b0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            job_valid_reg    <= 1'b0;
            job_idx_reg      <= 3'd0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    dtrd_pkg::REG_MEM_TYPE:      dram_type_reg    <= cfg_wdata[2:0];
                    dtrd_pkg::REG_DATA_RATE:     dram_rate_reg    <= cfg_wdata;
                    dtrd_pkg::REG_REVERSE_BITS:  reverse_bits_reg <= cfg_wdata[0];
                    dtrd_pkg::REG_REFRESH_COUNT: reg_count_reg    <= cfg_wdata[3:0];
                    default: ;
                endcase
            end

            // stored level moves only on a supported, changed level
            if (s1_fire && s1_supported && s1_changed) begin
                last_level_reg  <= s1_level;
                level_known_reg <= 1'b1;
            end

            if (s1_free) s1_valid_reg <= s_tvalid;
            if (s2_free) s2_valid_reg <= s1_valid_reg && s1_emit;
            if (s3_free) s3_valid_reg <= s2_valid_reg;

            if (job_free) begin
                job_valid_reg <= s3_valid_reg;
                job_idx_reg   <= 3'd0;
            end else if (emit) begin
                job_idx_reg   <= job_idx_reg + 3'd1;
            end

            if (out_load_ok) m_valid_reg <= job_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s1_free) s1_word_reg <= s_tdata;
        if (s1_fire) begin
            s2_prod_reg  <= s1_prod;
            s2_level_reg <= s1_level;
            s2_count_reg <= s1_count;
        end
        if (s2_valid_reg && s3_free) begin
            s3_prod_reg  <= s2_prod_reg;
            s3_quot_reg  <= s2_wide[32 +: dtrd_pkg::FULL_W];
            s3_level_reg <= s2_level_reg;
            s3_count_reg <= s2_count_reg;
        end
        if (s3_valid_reg && job_free) begin
            job_full_reg  <= s3_full;
            job_level_reg <= s3_level_reg;
            job_count_reg <= s3_count_reg;
        end
        if (emit) begin
            m_index_reg <= job_idx_reg;
            m_value_reg <= job_value;
            m_level_reg <= job_level_reg;
            m_last_reg  <= job_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_level_reg, m_value_reg, m_index_reg};
    assign m_tlast  = m_last_reg;

endmodule
`default_nettype wire

>>> verif/dtrd_refresh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtrd_refresh_checker: result checker for the thermal refresh derate block
// follows register writes and sensor requests, predicts the refresh updates
// each request causes and compares them in order with the m_ channel
// ----------------------------------------------------------------------------
module dtrd_refresh_checker
    import dtrd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [31:0]           s_tdata,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [23:0]           m_tdata,
    input  wire logic                  m_tlast,
    output int unsigned                fail_count,
    output logic                       busy
);

    typedef struct packed {
        logic [2:0]  reg_index;
        logic [15:0] refresh_value;
        logic [2:0]  level;
        logic        last_of_run;
    } refresh_update_t;

    refresh_update_t pending_updates[$];

    // shadow of the block's registers and level memory
    logic [2:0]  cur_type;
    logic [15:0] cur_rate;
    logic        cur_reverse;
    logic [3:0]  cur_count;
    logic [2:0]  stored_level;
    logic        level_seen;

    initial begin
        fail_count = 0;
        busy       = 1'b0;
    end

    // percent of the base interval for a type and level
    function automatic logic [10:0] derate_percent(input logic [2:0] mem_type,
                                                   input logic [2:0] lvl);
        logic [10:0] pct;
        pct = 11'd0;
        if (mem_type == DRAM_DDR4) begin
            case (lvl[1:0])
                2'd0, 2'd1: pct = 11'd780;
                2'd2:       pct = 11'd390;
                default:    pct = 11'd195;
            endcase
        end else if (mem_type == DRAM_LPDDR4) begin
            case (lvl)
                3'd0, 3'd1: pct = 11'd1560;
                3'd2:       pct = 11'd780;
                3'd3:       pct = 11'd390;
                3'd4:       pct = 11'd195;
                3'd5, 3'd6: pct = 11'd97;
                default:    pct = 11'd48;
            endcase
        end
        return pct;
    endfunction

    task automatic predict_refresh_updates(input logic [31:0] word);
        logic [2:0]      lvl;
        logic [31:0]     base;
        logic [31:0]     full;
        logic [31:0]     shifted;
        int unsigned     n;
        refresh_update_t upd;
        if (cur_type == DRAM_DDR4)
            lvl = cur_reverse ? {1'b0, word[3], word[4]} : {1'b0, word[4], word[3]};
        else if (cur_type == DRAM_LPDDR4)
            lvl = word[2:0];
        else if (cur_type == DRAM_LPDDR5)
            lvl = {2'b00, word[0]};
        else
            return;
        if (level_seen && lvl == stored_level)
            return;
        stored_level = lvl;
        level_seen   = 1'b1;
        base = (cur_rate >= 16'd2) ? (32'(cur_rate >> 1) - 32'd1) : 32'd0;
        full = base * 32'(derate_percent(cur_type, lvl)) / 32'd100;
        n    = (cur_count > MAX_REGS) ? 32'(MAX_REGS) : 32'(cur_count);
        for (int unsigned j = 0; j < n; j++) begin
            shifted = full >> j;
            upd.reg_index     = j[2:0];
            upd.refresh_value = (shifted > 32'h0000_ffff) ? 16'hffff : shifted[15:0];
            upd.level         = lvl;
            upd.last_of_run   = (j + 1 == n);
            pending_updates.push_back(upd);
        end
    endtask

    task automatic compare_field(input string name, input int unsigned exp_val,
                                 input int unsigned act_val);
        if (exp_val != act_val) begin
            $display("%0t refresh update %s: expected %0d, got %0d",
                     $time, name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        refresh_update_t exp_upd;
        if (!aresetn) begin
            pending_updates.delete();
            cur_type     = DRAM_DDR4;
            cur_rate     = 16'd0;
            cur_reverse  = 1'b0;
            cur_count    = 4'd1;
            stored_level = 3'd0;
            level_seen   = 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_MEM_TYPE:      cur_type    = cfg_wdata[2:0];
                    REG_DATA_RATE:     cur_rate    = cfg_wdata[15:0];
                    REG_REVERSE_BITS:  cur_reverse = cfg_wdata[0];
                    REG_REFRESH_COUNT: cur_count   = cfg_wdata[3:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_refresh_updates(s_tdata);
            if (m_tvalid && m_tready) begin
                if (pending_updates.size() == 0) begin
                    $display("%0t refresh update with none pending: %s reg %0d value %0d",
                             $time, "expected nothing, got", m_tdata[2:0], m_tdata[18:3]);
                    fail_count++;
                end else begin
                    exp_upd = pending_updates.pop_front();
                    compare_field("reg_index", exp_upd.reg_index, m_tdata[2:0]);
                    compare_field("refresh_value", exp_upd.refresh_value, m_tdata[18:3]);
                    compare_field("level", exp_upd.level, m_tdata[21:19]);
                    compare_field("last_of_run", exp_upd.last_of_run, m_tlast);
                end
            end
        end
        busy <= (pending_updates.size() != 0);
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the thermal refresh derate block
// directed sensor words over every memory type and register corner, then
// random words under several register settings and handshake stall patterns
// ----------------------------------------------------------------------------
module testbench;
    import dtrd_pkg::*;

    // cycles with no request, result or register write before giving up
    localparam int unsigned QUIET_LIMIT = 1000;
    // cycles the receiver holds off once to fill the pipeline
    localparam int unsigned HOLD_CYCLES = 100;
    // settle time after the last result, covers requests with no result
    localparam int unsigned DRAIN_CYCLES = 16;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata   = '0;   // [31:0] sensor_word
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [23:0]           m_tdata;          // [2:0] reg_index, [18:3] refresh_value,
                                             // [21:19] level, [23:22] zero
    logic                  m_tlast;          // last_of_run

    int unsigned fail_count;
    logic        busy;

    // stall controls, percent of cycles
    int unsigned s_idle_pct  = 0;
    int unsigned m_stall_pct = 0;

    // one-shot long receiver hold-off
    logic        rx_hold_go   = 1'b0;
    logic        rx_hold_used = 1'b0;
    int unsigned hold_left    = 0;

    int unsigned quiet_cycles = 0;

    always #5 aclk = ~aclk;

    dram_thermal_refresh_derate i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    dtrd_refresh_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .busy       (busy)
    );

    // result side: random stalls, plus a single long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold_go && !rx_hold_used) begin
            rx_hold_used <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            m_tready     <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= m_stall_pct);
        end
    end

    // watchdog: any handshake or register write counts as progress
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // offer one sensor request, with random idle cycles ahead of it
    task automatic send_sensor_word(input logic [31:0] word);
        while ($urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop offering and wait until every expected update has come out
    task automatic wait_idle(input int unsigned settle);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (busy);
        repeat (settle) @(posedge aclk);
    endtask

    // write all four registers back to back; the block must be idle
    task automatic load_settings(input logic [2:0] mem_type, input logic [15:0] rate,
                                 input logic rev, input logic [3:0] cnt);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_MEM_TYPE;
        cfg_wdata <= CFG_DATA_W'(mem_type);
        @(posedge aclk);
        cfg_addr  <= REG_DATA_RATE;
        cfg_wdata <= rate;
        @(posedge aclk);
        cfg_addr  <= REG_REVERSE_BITS;
        cfg_wdata <= CFG_DATA_W'(rev);
        @(posedge aclk);
        cfg_addr  <= REG_REFRESH_COUNT;
        cfg_wdata <= CFG_DATA_W'(cnt);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [31:0] word;
        logic [31:0] prev_word;
        logic [2:0]  mem_type;
        logic [15:0] rate;
        logic [3:0]  cnt;
        int unsigned pick;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // -------- directed part, no stalls --------

        // register defaults: ddr4, rate zero clamps the interval to zero
        send_sensor_word(32'h0000_0000);        // first level ever seen
        send_sensor_word(32'h0000_0000);        // same level, no update
        send_sensor_word(32'h0000_0008);        // level one

        // full rate, eight registers: the first value of the level-two run saturates
        wait_idle(DRAIN_CYCLES);
        load_settings(DRAM_DDR4, 16'hffff, 1'b0, 4'd8);
        send_sensor_word(32'hffff_ffff);
        send_sensor_word(32'h0000_0010);

        // ddr4 with swapped level bits, rate two gives a zero base
        wait_idle(DRAIN_CYCLES);
        load_settings(DRAM_DDR4, 16'd2, 1'b1, 4'd3);
        send_sensor_word(32'h0000_0008);
        send_sensor_word(32'h0000_0010);

        // lpddr4 every level; count above the cap, swap flag has no effect
        wait_idle(DRAIN_CYCLES);
        load_settings(DRAM_LPDDR4, 16'hffff, 1'b1, 4'd15);
        for (int lvl = 0; lvl < 8; lvl++)
            send_sensor_word(($urandom & 32'hffff_fff8) | 32'(lvl));

        // lpddr5 with zero count: level is stored, nothing comes out
        wait_idle(DRAIN_CYCLES);
        load_settings(DRAM_LPDDR5, 16'd3, 1'b0, 4'd0);
        send_sensor_word(32'h0000_0001);
        send_sensor_word(32'h0000_0000);

        // lpddr5, rate one: coefficients are zero anyway
        wait_idle(DRAIN_CYCLES);
        load_settings(DRAM_LPDDR5, 16'd1, 1'b0, 4'd2);
        send_sensor_word(32'hffff_ffff);
        send_sensor_word(32'h0000_0001);    // same level as before

        // every unsupported type: no update whatever the word
        for (int t = 0; t < 8; t++) begin
            if (3'(t) != DRAM_DDR4 && 3'(t) != DRAM_LPDDR4 && 3'(t) != DRAM_LPDDR5) begin
                wait_idle(DRAIN_CYCLES);
                load_settings(3'(t), 16'd1000, 1'b0, 4'd4);
                send_sensor_word($urandom);
            end
        end

        // -------- random part --------
        prev_word = '0;
        for (int phase = 0; phase < 8; phase++) begin
            wait_idle(DRAIN_CYCLES);

            // stall pattern rotates: none, sender idle, receiver stall, both
            case (phase % 4)
                0:       begin s_idle_pct = 0;  m_stall_pct <= 0;  end
                1:       begin s_idle_pct = 60; m_stall_pct <= 0;  end
                2:       begin s_idle_pct = 0;  m_stall_pct <= 60; end
                default: begin s_idle_pct = 20; m_stall_pct <= 20; end
            endcase

            pick = $urandom_range(9);
            if (pick < 5)
                mem_type = DRAM_LPDDR4;
            else if (pick < 9)
                mem_type = DRAM_DDR4;
            else
                mem_type = DRAM_LPDDR5;

            pick = $urandom_range(7);
            case (pick)
                0:       rate = 16'd0;
                1:       rate = 16'd1;
                2:       rate = 16'd2;
                3:       rate = 16'hffff;
                default: rate = 16'($urandom_range(65535));
            endcase

            pick = $urandom_range(9);
            if (pick == 0)
                cnt = 4'd0;
            else if (pick == 1)
                cnt = 4'($urandom_range(9, 15));
            else
                cnt = 4'($urandom_range(1, 8));

            if (phase == 0) begin
                // heaviest load while the receiver holds off: the pipeline
                // fills and the request side has to stall
                mem_type = DRAM_LPDDR4;
                rate     = 16'hffff;
                cnt      = MAX_REGS;
                rx_hold_go <= 1'b1;
            end
            load_settings(mem_type, rate, 1'($urandom_range(1)), cnt);

            for (int n = 0; n < 14; n++) begin
                // a repeated word keeps the level, so no update follows
                if (n > 0 && $urandom_range(3) == 0)
                    word = prev_word;
                else
                    word = $urandom;
                // once, the sender waits for every update to drain
                if (phase == 5 && n == 8)
                    wait_idle(0);
                send_sensor_word(word);
                prev_word = word;
            end
        end

        wait_idle(DRAIN_CYCLES);
        if (fail_count == 0 && !busy)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
